@@ src/pcc_pkg.sv @@
// Package for the permutation cycle counter.
// Holds sizes, the link memory entry and request types and the walker states.
// No dependencies.
package pcc_pkg;

    localparam int MAX_N = 1024;
    localparam int IDX_W = $clog2(MAX_N);
    localparam int LEN_W = $clog2(MAX_N + 1);
    localparam int VAL_W = 11;
    localparam int CNT_W = 11;

    typedef struct packed {
        logic             seen;
        logic [IDX_W-1:0] link;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_WALK,
        ST_FIN
    } walk_state_t;

endpackage

@@ src/pcc_mem.sv @@
// Link memory: one entry per position, visited bit beside the zero-based link.
// Synchronous, one write and one read port, registered read data.
// Depends on pcc_pkg.
module pcc_mem
    import pcc_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t mem [MAX_N];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

@@ src/pcc_loader.sv @@
// Loader: stores entries, up to MAX_N, as links with a cleared visited bit,
// and tracks the set length and the largest entry. Depends on pcc_pkg.
module pcc_loader
    import pcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             beat_en,
    input  logic [VAL_W-1:0] entry_value,
    input  logic             clear,
    output logic [LEN_W-1:0] len,
    output logic [VAL_W-1:0] max_val,
    output mem_req_t         req
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [VAL_W-1:0] max_reg, max_next;
    logic [VAL_W-1:0] eff;
    logic [VAL_W-1:0] dec;
    logic             room;

    always_comb
    begin
        eff  = (entry_value == '0) ? '1 : entry_value;
        dec  = entry_value - VAL_W'(1);
        room = (len_reg < LEN_W'(MAX_N));

        len_next = len_reg;
        max_next = max_reg;
        if (clear)
        begin
            len_next = '0;
            max_next = '0;
        end
        else if (beat_en)
        begin
            if (eff > max_reg)
            begin
                max_next = eff;
            end
            if (room)
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end

        req            = '0;
        req.we         = beat_en && room;
        req.waddr      = len_reg[IDX_W-1:0];
        req.wdata.seen = 1'b0;
        req.wdata.link = dec[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            max_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            max_reg <= max_next;
        end
    end

    assign len     = len_reg;
    assign max_val = max_reg;

endmodule

@@ src/pcc_walker.sv @@
// Walker: checks the loaded set, then scans positions and follows links,
// marking visited entries with read-modify-write. Depends on pcc_pkg.
module pcc_walker
    import pcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LEN_W-1:0] len,
    input  logic [VAL_W-1:0] max_val,
    input  entry_t           rdata,
    input  logic             out_free,
    output mem_req_t         req,
    output logic             busy,
    output logic             clear,
    output logic             res_valid,
    output logic [CNT_W-1:0] res_count,
    output logic             res_bad
);

    walk_state_t      state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             bad_reg, bad_next;
    logic             fwd_reg, fwd_next;

    logic             seen;
    logic             bad_chk;
    logic [LEN_W-1:0] idx_inc;
    logic             idx_end;

    assign seen    = rdata.seen | fwd_reg;
    assign bad_chk = (max_val > VAL_W'(len));
    assign idx_inc = idx_reg + LEN_W'(1);
    assign idx_end = (idx_inc == len);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = bad_chk ? ST_FIN : ST_SCAN;
            end
            ST_SCAN, ST_WALK:
            begin
                if (!seen)
                begin
                    state_next = ST_WALK;
                end
                else if (idx_end)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req       = '0;
        busy      = 1'b1;
        clear     = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_CHECK:
            begin
                req.re    = !bad_chk;
                req.raddr = '0;
            end
            ST_SCAN:
            begin
                if (!seen)
                begin
                    req.re    = 1'b1;
                    req.raddr = rdata.link;
                end
                else
                begin
                    req.re    = !idx_end;
                    req.raddr = idx_inc[IDX_W-1:0];
                end
            end
            ST_WALK:
            begin
                if (!seen)
                begin
                    req.we         = 1'b1;
                    req.waddr      = cur_reg;
                    req.wdata.seen = 1'b1;
                    req.wdata.link = rdata.link;
                    req.re         = 1'b1;
                    req.raddr      = rdata.link;
                end
                else
                begin
                    req.re    = !idx_end;
                    req.raddr = idx_inc[IDX_W-1:0];
                end
            end
            ST_FIN:
            begin
                res_valid = out_free;
                clear     = out_free;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        bad_next = bad_reg;
        cur_next = req.re ? req.raddr : cur_reg;
        fwd_next = req.re && req.we && (req.raddr == req.waddr);
        case (state_reg)
            ST_CHECK:
            begin
                idx_next = '0;
                cnt_next = '0;
                bad_next = bad_chk;
            end
            ST_SCAN:
            begin
                if (seen)
                begin
                    idx_next = idx_inc;
                end
            end
            ST_WALK:
            begin
                if (seen)
                begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fwd_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fwd_reg   <= fwd_next;
            bad_reg   <= bad_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
    end

    assign res_count = cnt_reg;
    assign res_bad   = bad_reg;

endmodule

@@ src/permutation_cycle_counter_unit.sv @@
// Permutation cycle counter, top level: input and output beats, loader,
// walker and link memory. Depends on pcc_pkg, pcc_mem, pcc_loader, pcc_walker.
//
// Each input beat carries one entry of a permutation of 1..n (one-based) and
// is stored at the next position; tlast marks the final entry. In the cycle after
// the final beat the set is checked: an entry of zero or above n gives a
// result with bad_entry set and a count of zero. Otherwise the block scans the
// positions in order, following links through the link memory (one read port
// and one write port, one access of each per cycle), and reports the number of
// cycles found.
// Input is not taken during the walk; loading of the next set may proceed while a
// result waits on the output. Entries past 1024 are not stored but still count
// toward the range check.
module permutation_cycle_counter_unit
    import pcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] entry_value, [15:11] zero
    input  logic        s_tlast,   // last_entry
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] cycle_count, [15:11] zero
    output logic        m_tuser    // bad_entry
);

    logic             beat_en;
    logic             busy;
    logic             clear;
    logic             out_free;
    logic             res_valid;
    logic [CNT_W-1:0] res_count;
    logic             res_bad;
    logic [LEN_W-1:0] len;
    logic [VAL_W-1:0] max_val;
    mem_req_t         ld_req;
    mem_req_t         wk_req;
    mem_req_t         mem_req;
    entry_t           rdata;

    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_bad_reg;

    assign s_tready = !busy;
    assign beat_en  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        mem_req       = wk_req;
        mem_req.we    = ld_req.we | wk_req.we;
        mem_req.waddr = ld_req.we ? ld_req.waddr : wk_req.waddr;
        mem_req.wdata = ld_req.we ? ld_req.wdata : wk_req.wdata;
    end

    pcc_loader u_loader (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_en     (beat_en),
        .entry_value (s_tdata[VAL_W-1:0]),
        .clear       (clear),
        .len         (len),
        .max_val     (max_val),
        .req         (ld_req)
    );

    pcc_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (beat_en && s_tlast),
        .len       (len),
        .max_val   (max_val),
        .rdata     (rdata),
        .out_free  (out_free),
        .req       (wk_req),
        .busy      (busy),
        .clear     (clear),
        .res_valid (res_valid),
        .res_count (res_count),
        .res_bad   (res_bad)
    );

    pcc_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_count_reg <= res_count;
            out_bad_reg   <= res_bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - CNT_W){1'b0}}, out_count_reg};
    assign m_tuser  = out_bad_reg;

endmodule

@@ src/pcc_checker.sv @@
// Port checker for the permutation cycle counter, bound to the top level.
// Watches only the top-level ports. No package dependencies.
module pcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[10:0] == 11'd0)
        else $error("bad set reported a nonzero count");

    a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[10:0] != 11'd0)
        else $error("valid set reported no cycles");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:11] == 5'd0)
        else $error("padding bits set");

    a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after final beat");

endmodule

bind permutation_cycle_counter_unit pcc_checker u_pcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for permutation_cycle_counter_unit: streams permutations and broken sets,
// predicts each cycle count by walking the links, and checks every result beat.
// Depends on pcc_pkg and the RTL sources.
module testbench;
    import pcc_pkg::*;

    localparam int HOLD_LEN    = 400;
    localparam int IDLE_LIMIT  = 20000;
    localparam int PHASE_ITEMS = 110;
    localparam int TAIL_CYCLES = 50;
    localparam int BIG_SET     = 256;

    typedef struct {
        bit [CNT_W-1:0] count;
        bit             bad;
    } loop_result_t;

    class cycle_scoreboard;
        bit [IDX_W-1:0] links [MAX_N];
        int unsigned    n_loaded;
        bit [VAL_W-1:0] top_entry;
        loop_result_t   expected_q[$];
        int             errors;
        int             sets;
        int             bad_sets;
        int             checked;
        int             entries;

        function bit [CNT_W-1:0] count_loops();
            bit          seen [MAX_N];
            int unsigned cnt;
            int unsigned j;
            cnt = 0;
            foreach (seen[k])
                seen[k] = 1'b0;
            for (int unsigned i = 0; i < n_loaded; i++)
            begin
                if (!seen[i])
                begin
                    j = links[i];
                    while (!seen[j])
                    begin
                        seen[j] = 1'b1;
                        j = links[j];
                    end
                    cnt++;
                end
            end
            return CNT_W'(cnt);
        endfunction

        function void note_entry(bit [VAL_W-1:0] v, bit last);
            bit [VAL_W-1:0] eff;
            loop_result_t   r;
            entries++;
            eff = (v == 0) ? '1 : v;
            if (eff > top_entry)
                top_entry = eff;
            if (n_loaded < MAX_N)
            begin
                links[n_loaded] = IDX_W'(v - 1'b1);
                n_loaded++;
            end
            if (!last)
                return;
            r.bad   = top_entry > n_loaded;
            r.count = r.bad ? '0 : count_loops();
            expected_q = {expected_q, r};
            sets++;
            if (r.bad)
                bad_sets++;
            n_loaded  = 0;
            top_entry = '0;
        endfunction

        function void check_result(bit [CNT_W-1:0] count, bit bad);
            loop_result_t r;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: cycle_count %0d bad_entry %0d",
                       count, bad);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            checked++;
            if (count !== r.count)
            begin
                $error("cycle_count mismatch: expected %0d, got %0d", r.count, count);
                errors++;
            end
            if (bad !== r.bad)
            begin
                $error("bad_entry mismatch: expected %0d, got %0d", r.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        hold_req = 1'b0;

    int              hold_cnt   = 0;
    int              idle_cnt   = 0;
    int              sender_pct = 0;
    int              stall_pct  = 0;
    int              items_sent = 0;
    int              set_vals[$];
    cycle_scoreboard sb;

    permutation_cycle_counter_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hold off the output for a counted stretch once requested
    always @(posedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_LEN)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
            m_tready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_entry(s_tdata[VAL_W-1:0], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[CNT_W-1:0], m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt <= 0;
            else if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

    task automatic send_beat(input int v, input bit last);
        while (sender_pct != 0 && $urandom_range(99, 0) < sender_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, VAL_W'(v)};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_set();
        foreach (set_vals[i])
            send_beat(set_vals[i], i == set_vals.size() - 1);
    endtask

    // drop valid after the last accepted beat so it is not taken again
    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void build_perm(int n);
        int j;
        int tmp;
        set_vals = {};
        for (int i = 1; i <= n; i++)
            set_vals = {set_vals, i};
        for (int i = n - 1; i > 0; i--)
        begin
            j           = $urandom_range(i, 0);
            tmp         = set_vals[i];
            set_vals[i] = set_vals[j];
            set_vals[j] = tmp;
        end
    endfunction

    // mostly clean permutations, then duplicates, one-entry corruption and noise
    function automatic void build_random_set();
        int kind;
        int n;
        kind = $urandom_range(99, 0);
        n    = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(16, 1);
        if (kind < 70)
            build_perm(n);
        else if (kind < 80)
        begin
            set_vals = {};
            for (int i = 0; i < n; i++)
                set_vals = {set_vals, int'($urandom_range(n, 1))};
        end
        else if (kind < 90)
        begin
            build_perm(n);
            set_vals[$urandom_range(n - 1, 0)] = $urandom_range(2047, 0);
        end
        else
        begin
            set_vals = {};
            n = $urandom_range(8, 1);
            for (int i = 0; i < n; i++)
                set_vals = {set_vals, int'($urandom_range(2047, 0))};
        end
    endfunction

    task automatic wait_drained();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_modes  [4];
        int stall_modes [4];
        int phase_start;
        sb = new();
        idle_modes  = '{0, 83, 0, 29};
        stall_modes = '{0, 0, 83, 29};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_vals = {1};             send_set();
        set_vals = {1, 2, 3};       send_set();
        set_vals = {2, 3, 1};       send_set();
        set_vals = {2, 1, 4, 3};    send_set();
        set_vals = {2, 2, 1};       send_set();
        set_vals = {0, 1};          send_set();
        set_vals = {3, 1};          send_set();
        set_vals = {2047};          send_set();
        set_vals = {1024, 1};       send_set();

        // one large set
        build_perm(BIG_SET);
        send_set();
        stop_sending();
        wait_drained();

        // stall the output while input keeps coming
        hold_req <= 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            build_perm($urandom_range(12, 4));
            send_set();
        end
        stop_sending();
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            sender_pct  = idle_modes[ph];
            stall_pct   = stall_modes[ph];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                build_random_set();
                send_set();
            end
        end
        stop_sending();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d entries in %0d sets (%0d with a bad entry), %0d results checked",
                 sb.entries, sb.sets, sb.bad_sets, sb.checked);
        $display("set sizes up to %0d entries, output held off for %0d cycles under load",
                 BIG_SET, HOLD_LEN);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
